@@ src/cs_pkg.sv @@
// Shared widths and defaults for the cosine similarity block.
package cs_pkg;

  // Accumulator width for the dot product and the squared norms
  localparam int ACC_W = 48;
  // Operand width of the shared multiplier (half an accumulator)
  localparam int MUL_W = ACC_W / 2;
  // Full product of two accumulators
  localparam int WIDE_W = 2 * ACC_W;
  // Partial products needed for one accumulator by accumulator product
  localparam int PART_CNT = (ACC_W / MUL_W) * (ACC_W / MUL_W);
  // Fraction bits of the result and bits of its magnitude
  localparam int FRAC_BITS = 14;
  localparam int Q_W = FRAC_BITS + 1;
  localparam int SIM_W = 16;
  // Working width of the root search: (2^Q_W)^2 times a wide product
  localparam int ROOT_W = WIDE_W + 2 * Q_W;

  // Defaults for the top level parameters
  localparam int MAX_LEN_DEF = 1024;
  localparam int ELEM_WIDTH_DEF = 16;

endpackage

@@ src/cosine_similarity.sv @@
// Cosine similarity of two streamed fixed-point vectors.
//
// Input channel (pair_valid / pair_ready) carries one element pair per
// transfer, signed Q1.15, with last_pair marking the final pair. Output
// channel (result_valid / result_ready) carries one result per vector:
// similarity in signed Q1.14 truncated toward zero, plus zero_norm and
// too_long flags, either of which forces similarity to 0.
// Each pair runs through S_MUL_AB, S_MUL_AA, S_MUL_BB and S_ADD_BB before
// ready returns: the single 24x24 multiplier forms a*b, a*a and b*b in
// turn, one a cycle. Pairs beyond MAX_LEN are dropped at the transfer and
// only set too_long. After the last pair, S_WIDE builds the two 96-bit
// products from four partial products each, then the root search settles
// the result one bit at a time, from the top bit down.
// The result sits in an output register; pairs of the next vector are
// taken while it waits, but a further result holds the block until the
// receiver takes the previous one. Synchronous reset clears all sums,
// the pair count and both channels.
module cosine_similarity #(
  parameter int MAX_LEN    = cs_pkg::MAX_LEN_DEF,
  parameter int ELEM_WIDTH = cs_pkg::ELEM_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               pair_valid,
  output logic                               pair_ready,
  input  logic signed [ELEM_WIDTH-1:0]       element_a,
  input  logic signed [ELEM_WIDTH-1:0]       element_b,
  input  logic                               last_pair,
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic signed [cs_pkg::SIM_W-1:0]    similarity,
  output logic                               zero_norm,
  output logic                               too_long
);
  import cs_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LEN);
  localparam logic [3:0] WIDE_LAST = 4'(2 * PART_CNT);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_AB,
    S_MUL_AA,
    S_MUL_BB,
    S_ADD_BB,
    S_FINAL,
    S_WIDE,
    S_ROOT,
    S_RESULT
  } state_t;

  state_t                  state;
  logic [ELEM_WIDTH-1:0]   mag_a;
  logic [ELEM_WIDTH-1:0]   mag_b;
  logic [ELEM_WIDTH-1:0]   mag_a_in;
  logic [ELEM_WIDTH-1:0]   mag_b_in;
  logic                    neg_ab;
  logic                    last_seen;
  logic [ACC_W-1:0]        dot_sum;
  logic [ACC_W-1:0]        norm_a_sum;
  logic [ACC_W-1:0]        norm_b_sum;
  logic [CNT_W-1:0]        pair_count;
  logic                    overflowed;
  logic [ACC_W-1:0]        dot_mag;
  logic                    dot_neg;
  logic [3:0]              step;
  logic [3:0]              step_m1;
  logic [WIDE_W-1:0]       p_wide;
  logic [WIDE_W-1:0]       r_wide;
  logic [WIDE_W-1:0]       pp_wide;
  logic [SIM_W-1:0]        res_sim;
  logic                    res_zero;
  logic                    res_long;
  logic                    root_start;
  logic                    root_done;
  logic [Q_W-1:0]          root_q;
  logic [MUL_W-1:0]        mul_x;
  logic [MUL_W-1:0]        mul_y;
  logic [2*MUL_W-1:0]      mul_prod;

  assign pair_ready = (state == S_IDLE);

  // Element magnitudes; the most negative code maps onto its own pattern
  assign mag_a_in = element_a[ELEM_WIDTH-1] ? $unsigned(-element_a) : $unsigned(element_a);
  assign mag_b_in = element_b[ELEM_WIDTH-1] ? $unsigned(-element_b) : $unsigned(element_b);

  // Select multiplier operands for the current step
  always_comb begin
    mul_x = '0;
    mul_y = '0;
    unique case (state)
      S_MUL_AB: begin
        mul_x = MUL_W'(mag_a);
        mul_y = MUL_W'(mag_b);
      end
      S_MUL_AA: begin
        mul_x = MUL_W'(mag_a);
        mul_y = MUL_W'(mag_a);
      end
      S_MUL_BB: begin
        mul_x = MUL_W'(mag_b);
        mul_y = MUL_W'(mag_b);
      end
      S_WIDE: begin
        if (step[2]) begin
          mul_x = step[1] ? dot_mag[ACC_W-1:MUL_W] : dot_mag[MUL_W-1:0];
          mul_y = step[0] ? dot_mag[ACC_W-1:MUL_W] : dot_mag[MUL_W-1:0];
        end else begin
          mul_x = step[1] ? norm_a_sum[ACC_W-1:MUL_W] : norm_a_sum[MUL_W-1:0];
          mul_y = step[0] ? norm_b_sum[ACC_W-1:MUL_W] : norm_b_sum[MUL_W-1:0];
        end
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  // Align the partial product issued in the previous cycle
  assign step_m1 = step - 4'd1;
  always_comb begin
    unique case (step_m1[1:0])
      2'd0:    pp_wide = WIDE_W'(mul_prod);
      2'd1:    pp_wide = WIDE_W'(mul_prod) << MUL_W;
      2'd2:    pp_wide = WIDE_W'(mul_prod) << MUL_W;
      default: pp_wide = WIDE_W'(mul_prod) << (2 * MUL_W);
    endcase
  end

  cs_mul u_mul (
    .clk  (clk),
    .x    (mul_x),
    .y    (mul_y),
    .prod (mul_prod)
  );

  cs_root u_root (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .p     (p_wide),
    .r     (r_wide),
    .done  (root_done),
    .q     (root_q)
  );

  // Sequencer, sums and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      dot_sum      <= '0;
      norm_a_sum   <= '0;
      norm_b_sum   <= '0;
      pair_count   <= '0;
      overflowed   <= 1'b0;
      root_start   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // Drop the result once the receiver takes it, unless a new one is loaded
      if (result_ready && (state != S_RESULT)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pair_valid) begin
            mag_a     <= mag_a_in;
            mag_b     <= mag_b_in;
            neg_ab    <= element_a[ELEM_WIDTH-1] ^ element_b[ELEM_WIDTH-1];
            last_seen <= last_pair;
            if (pair_count == CNT_MAX) begin
              overflowed <= 1'b1;
              state      <= last_pair ? S_FINAL : S_IDLE;
            end else begin
              state <= S_MUL_AB;
            end
          end
        end
        S_MUL_AB: begin
          state <= S_MUL_AA;
        end
        S_MUL_AA: begin
          dot_sum <= neg_ab ? dot_sum - mul_prod : dot_sum + mul_prod;
          state   <= S_MUL_BB;
        end
        S_MUL_BB: begin
          norm_a_sum <= norm_a_sum + mul_prod;
          state      <= S_ADD_BB;
        end
        S_ADD_BB: begin
          norm_b_sum <= norm_b_sum + mul_prod;
          pair_count <= pair_count + 1'b1;
          state      <= last_seen ? S_FINAL : S_IDLE;
        end
        S_FINAL: begin
          // Settle the flags; only a clean vector goes on to the search
          res_long <= overflowed;
          res_zero <= (norm_a_sum == '0) || (norm_b_sum == '0);
          res_sim  <= '0;
          dot_neg  <= dot_sum[ACC_W-1];
          dot_mag  <= dot_sum[ACC_W-1] ? -dot_sum : dot_sum;
          p_wide   <= '0;
          r_wide   <= '0;
          step     <= '0;
          if (overflowed || (norm_a_sum == '0) || (norm_b_sum == '0)) begin
            state <= S_RESULT;
          end else begin
            state <= S_WIDE;
          end
        end
        S_WIDE: begin
          // Sum partial products: first norm_a*norm_b, then dot*dot
          if (step != '0) begin
            if (step_m1[2]) begin
              r_wide <= r_wide + pp_wide;
            end else begin
              p_wide <= p_wide + pp_wide;
            end
          end
          if (step == WIDE_LAST) begin
            root_start <= 1'b1;
            state      <= S_ROOT;
          end else begin
            step <= step + 4'd1;
          end
        end
        S_ROOT: begin
          root_start <= 1'b0;
          if (root_done) begin
            res_sim <= dot_neg ? -SIM_W'(root_q) : SIM_W'(root_q);
            state   <= S_RESULT;
          end
        end
        S_RESULT: begin
          // Hand over the result and clear the sums for the next vector
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            similarity   <= res_sim;
            zero_norm    <= res_zero;
            too_long     <= res_long;
            dot_sum      <= '0;
            norm_a_sum   <= '0;
            norm_b_sum   <= '0;
            pair_count   <= '0;
            overflowed   <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ src/cs_mul.sv @@
// Shared unsigned multiplier with a registered product.
module cs_mul (
  input  logic                           clk,
  input  logic [cs_pkg::MUL_W-1:0]       x,
  input  logic [cs_pkg::MUL_W-1:0]       y,
  output logic [2*cs_pkg::MUL_W-1:0]     prod
);
  import cs_pkg::*;

  // Register the product every cycle; the sequencer picks the cycle it needs
  always_ff @(posedge clk) begin
    prod <= (2*MUL_W)'(x) * (2*MUL_W)'(y);
  end

endmodule

@@ src/cs_root.sv @@
// Bit-serial search for the largest q with q*q*p <= r*2^(2*FRAC_BITS).
module cs_root (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [cs_pkg::WIDE_W-1:0]   p,
  input  logic [cs_pkg::WIDE_W-1:0]   r,
  output logic                        done,
  output logic [cs_pkg::Q_W-1:0]      q
);
  import cs_pkg::*;

  localparam int K_W = $clog2(Q_W);
  localparam logic [K_W-1:0] K_TOP = K_W'(Q_W - 1);

  logic              busy;
  logic              phase;
  logic [K_W-1:0]    k;
  // s = q^2*p, v = q*p*2^(k+1), u = p*2^(2k), all scaled by 2^(2*FRAC_BITS)
  logic [ROOT_W-1:0] s;
  logic [ROOT_W-1:0] v;
  logic [ROOT_W-1:0] u;
  logic [ROOT_W-1:0] w;
  logic [ROOT_W-1:0] vu;
  logic [ROOT_W-1:0] rhs;
  logic [ROOT_W-1:0] cand;
  logic              fit;
  logic              last_bit;

  // Trial square with the current bit set, and its test against the bound
  assign cand = s + w;
  assign fit = (cand <= rhs);
  // Stop at bit zero, or at once when the top bit fits (q is then exactly one)
  assign last_bit = (k == '0) || (fit && (k == K_TOP));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // Flag completion on the second phase of the final bit
      done <= !start && busy && phase && last_bit;
      if (start) begin
        // Load operands and start at the top bit
        s     <= '0;
        v     <= '0;
        u     <= ROOT_W'(p) << (2 * FRAC_BITS);
        rhs   <= ROOT_W'(r) << (2 * FRAC_BITS);
        q     <= '0;
        k     <= K_TOP;
        phase <= 1'b0;
        busy  <= 1'b1;
      end else if (busy) begin
        if (!phase) begin
          // Form the increment and the next cross term
          w     <= v + u;
          vu    <= (v >> 1) + u;
          phase <= 1'b1;
        end else begin
          // Keep the bit if the trial square stays within the bound
          if (fit) begin
            s <= cand;
            q <= q | (Q_W'(1) << k);
            v <= vu;
          end else begin
            v <= v >> 1;
          end
          u     <= u >> 2;
          k     <= k - 1'b1;
          phase <= 1'b0;
          if (last_bit) begin
            busy <= 1'b0;
          end
        end
      end
    end
  end

endmodule

@@ dv/cosine_similarity_checker.sv @@
// Checker for the cosine similarity block: predicts each result and compares it.
module cosine_similarity_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pair_valid,
  input  logic                            pair_ready,
  input  logic signed [cs_pkg::ELEM_WIDTH_DEF-1:0] element_a,
  input  logic signed [cs_pkg::ELEM_WIDTH_DEF-1:0] element_b,
  input  logic                            last_pair,
  input  logic                            result_valid,
  input  logic                            result_ready,
  input  logic signed [cs_pkg::SIM_W-1:0] similarity,
  input  logic                            zero_norm,
  input  logic                            too_long,
  output int                              fault_count,
  output int                              results_due
);

  localparam int ACC_W     = cs_pkg::ACC_W;
  localparam int EW        = cs_pkg::ELEM_WIDTH_DEF;
  localparam int MAX_PAIRS = cs_pkg::MAX_LEN_DEF;
  localparam int ONE_Q14   = 1 << cs_pkg::FRAC_BITS;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic signed [cs_pkg::SIM_W-1:0] sim;
    logic                            zero;
    logic                            over;
  } cosine_t;

  // Results owed by the block, oldest first
  cosine_t          similarity_q[$];

  // Running sums of the vector in flight
  logic [ACC_W-1:0] dot_acc;
  logic [ACC_W-1:0] energy_a;
  logic [ACC_W-1:0] energy_b;
  int               pair_total;
  logic             overrun;

  // Fold one pair into the sums; on the last pair work out the cosine
  task automatic absorb_pair(input logic signed [EW-1:0] a, input logic signed [EW-1:0] b,
                             input logic lst);
    logic signed [2*EW-1:0] ab;
    logic signed [2*EW-1:0] aa;
    logic signed [2*EW-1:0] bb;
    logic [ACC_W-1:0]       mag;
    logic [127:0]           norm_prod;
    logic [127:0]           bound;
    int unsigned            lo;
    int unsigned            hi;
    int unsigned            mid;
    cosine_t                outcome;
    ab = a * b;
    aa = a * a;
    bb = b * b;
    // Pairs past the length limit only raise the overrun flag
    if (pair_total >= MAX_PAIRS) begin
      overrun = 1'b1;
    end else begin
      dot_acc    = dot_acc + {{(ACC_W-2*EW){ab[2*EW-1]}}, ab};
      energy_a   = energy_a + {{(ACC_W-2*EW){1'b0}}, aa};
      energy_b   = energy_b + {{(ACC_W-2*EW){1'b0}}, bb};
      pair_total = pair_total + 1;
    end
    if (lst) begin
      outcome.sim  = '0;
      outcome.over = overrun;
      outcome.zero = (energy_a == '0) || (energy_b == '0);
      if (!outcome.zero && !outcome.over) begin
        // Largest q with q^2 * |a|^2 * |b|^2 <= dot^2 * 2^28
        mag       = dot_acc[ACC_W-1] ? (~dot_acc + 1'b1) : dot_acc;
        norm_prod = 128'(energy_a) * 128'(energy_b);
        bound     = (128'(mag) * 128'(mag)) << (2 * cs_pkg::FRAC_BITS);
        lo = 0;
        hi = ONE_Q14;
        while (lo < hi) begin
          mid = (lo + hi + 1) >> 1;
          if (128'(mid * mid) * norm_prod <= bound)
            lo = mid;
          else
            hi = mid - 1;
        end
        outcome.sim = dot_acc[ACC_W-1] ? (16'sd0 - 16'(lo)) : 16'(lo);
      end
      similarity_q = {similarity_q, outcome};
      dot_acc    = '0;
      energy_a   = '0;
      energy_b   = '0;
      pair_total = 0;
      overrun    = 1'b0;
    end
  endtask

  // Check results before absorbing the pair of the same edge
  always @(posedge clk) begin
    cosine_t want;
    cosine_t seen;
    if (rst) begin
      similarity_q.delete();
      dot_acc    = '0;
      energy_a   = '0;
      energy_b   = '0;
      pair_total = 0;
      overrun    = 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        seen = '{sim: similarity, zero: zero_norm, over: too_long};
        if (similarity_q.size() == 0) begin
          fault_count = fault_count + 1;
          if (fault_count <= REPORT_MAX)
            $display("%0t: result with none owed: similarity %0d zero_norm %0b too_long %0b",
                     $realtime, seen.sim, seen.zero, seen.over);
        end else begin
          want = similarity_q.pop_front();
          if (want !== seen) begin
            fault_count = fault_count + 1;
            if (fault_count <= REPORT_MAX)
              $display({"%0t: result mismatch: similarity exp %0d got %0d, ",
                        "zero_norm exp %0b got %0b, too_long exp %0b got %0b"},
                       $realtime, want.sim, seen.sim, want.zero, seen.zero,
                       want.over, seen.over);
          end
        end
      end
      if (pair_valid && pair_ready)
        absorb_pair(element_a, element_b, last_pair);
    end
    results_due = similarity_q.size();
  end

endmodule

@@ dv/tb_cosine_similarity.sv @@
// Testbench top for the cosine similarity block: clock, reset, stimulus and verdict.
module tb_cosine_similarity;

  localparam int EW            = cs_pkg::ELEM_WIDTH_DEF;
  localparam int MAX_PAIRS     = cs_pkg::MAX_LEN_DEF;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 100;
  localparam int PHASE_PAIRS   = 80;

  typedef enum {VEC_RANDOM, VEC_ZERO_A, VEC_ZERO_B, VEC_SAME, VEC_NEGATED, VEC_LATE_A} vec_kind_t;

  logic                            clk;
  logic                            rst;
  logic                            pair_valid;
  logic                            pair_ready;
  logic signed [EW-1:0]            element_a;
  logic signed [EW-1:0]            element_b;
  logic                            last_pair;
  logic                            result_valid;
  logic                            result_ready;
  logic signed [cs_pkg::SIM_W-1:0] similarity;
  logic                            zero_norm;
  logic                            too_long;

  int fault_count;
  int results_due;
  int send_idle_pct;
  int sink_stall_pct;
  int cycle_count;

  cosine_similarity dut (
    .clk(clk), .rst(rst),
    .pair_valid(pair_valid), .pair_ready(pair_ready),
    .element_a(element_a), .element_b(element_b), .last_pair(last_pair),
    .result_valid(result_valid), .result_ready(result_ready),
    .similarity(similarity), .zero_norm(zero_norm), .too_long(too_long)
  );

  cosine_similarity_checker checker_i (
    .clk(clk), .rst(rst),
    .pair_valid(pair_valid), .pair_ready(pair_ready),
    .element_a(element_a), .element_b(element_b), .last_pair(last_pair),
    .result_valid(result_valid), .result_ready(result_ready),
    .similarity(similarity), .zero_norm(zero_norm), .too_long(too_long),
    .fault_count(fault_count), .results_due(results_due)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Stall the result side at random
  always @(negedge clk) begin
    result_ready <= !rst && ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Abandon a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Element values weighted towards the extremes and small magnitudes
  function automatic logic signed [EW-1:0] pick_element();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(EW-1){1'b0}}};
      1:       return {1'b0, {(EW-1){1'b1}}};
      2:       return '0;
      3:       return EW'(int'($urandom_range(0, 8)) - 4);
      default: return EW'($urandom);
    endcase
  endfunction

  // Offer one pair and hold it until the transfer; returns just after a falling edge
  task automatic send_pair(input logic signed [EW-1:0] a, input logic signed [EW-1:0] b,
                           input logic lst);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pair_valid <= 1'b0;
      @(negedge clk);
    end
    pair_valid <= 1'b1;
    element_a  <= a;
    element_b  <= b;
    last_pair  <= lst;
    do @(posedge clk); while (!pair_ready);
    @(negedge clk);
  endtask

  task automatic send_vector(input int len, input vec_kind_t kind);
    logic signed [EW-1:0] a;
    logic signed [EW-1:0] b;
    for (int i = 0; i < len; i++) begin
      a = pick_element();
      b = pick_element();
      case (kind)
        VEC_ZERO_A:  a = '0;
        VEC_ZERO_B:  b = '0;
        VEC_SAME:    b = a;
        VEC_NEGATED: b = -a;
        VEC_LATE_A:  if (i < MAX_PAIRS) a = '0;
        default:     ;
      endcase
      send_pair(a, b, i == len - 1);
    end
  endtask

  // Random vectors, mostly short, under one idling mix
  task automatic run_phase(input int idle_pct, input int stall_pct, input int budget);
    int        sent;
    int        len;
    vec_kind_t kind;
    send_idle_pct  = idle_pct;
    sink_stall_pct = stall_pct;
    sent = 0;
    while (sent < budget) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      case ($urandom_range(0, 19))
        0:       kind = VEC_ZERO_A;
        1:       kind = VEC_ZERO_B;
        2:       kind = VEC_SAME;
        3:       kind = VEC_NEGATED;
        default: kind = VEC_RANDOM;
      endcase
      send_vector(len, kind);
      sent = sent + len;
    end
  endtask

  // Hold the sender off until every owed result has arrived
  task automatic hold_until_drained();
    pair_valid <= 1'b0;
    @(negedge clk);
    while (results_due != 0) @(negedge clk);
  endtask

  initial begin
    rst            = 1'b1;
    pair_valid     = 1'b0;
    element_a      = '0;
    element_b      = '0;
    last_pair      = 1'b0;
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Full-scale parallel and antiparallel single pairs
    send_pair(-16'sd32768, -16'sd32768, 1'b1);
    send_pair(16'sd32767, -16'sd32768, 1'b1);
    send_pair(-16'sd32768, 16'sd32767, 1'b1);
    // Zero norm on either side or both
    send_pair(16'sd0, 16'sd0, 1'b1);
    send_pair(16'sd0, -16'sd1, 1'b1);
    send_pair(16'sd1, 16'sd0, 1'b1);
    send_pair(16'sd0, 16'sd5, 1'b0);
    send_pair(16'sd0, -16'sd7, 1'b1);
    // Smallest magnitudes
    send_pair(16'sd1, 16'sd1, 1'b1);
    send_pair(-16'sd1, 16'sd1, 1'b1);
    // Orthogonal vectors give zero without a flag
    send_pair(16'sd32767, 16'sd0, 1'b0);
    send_pair(16'sd0, 16'sd32767, 1'b1);
    // Partial cancellation in the dot product, then two full-scale parallel pairs
    send_pair(16'sd16384, 16'sd16384, 1'b0);
    send_pair(16'sd16384, -16'sd16384, 1'b0);
    send_pair(16'sd1, 16'sd1, 1'b1);
    send_pair(16'sd32767, 16'sd32767, 1'b0);
    send_pair(-16'sd32768, -16'sd32768, 1'b1);
    // Alternating bit patterns, then a full-scale and a unit element
    send_pair(16'sh5555, 16'shAAAA, 1'b0);
    send_pair(16'shAAAA, 16'sh5555, 1'b1);
    send_pair(16'sh7FFF, 16'sh0001, 1'b1);

    run_phase(0, 0, PHASE_PAIRS);
    hold_until_drained();
    run_phase(58, 0, PHASE_PAIRS);
    // One vector past the length limit, sometimes with a silent first vector
    send_vector(MAX_PAIRS + $urandom_range(1, 3),
                $urandom_range(0, 1) ? VEC_LATE_A : VEC_RANDOM);
    run_phase(0, 58, PHASE_PAIRS);
    run_phase(37, 37, PHASE_PAIRS);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (fault_count == 0 && results_due == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ filelist.f @@
src/cs_pkg.sv
src/cs_mul.sv
src/cs_root.sv
src/cosine_similarity.sv
dv/cosine_similarity_checker.sv
dv/tb_cosine_similarity.sv
